### design/bnre_pkg.sv
// ----------------------------------------------------------------------------
// Blanked noise RMS estimator package
// Shared widths, configuration register indexes, control types and the
// deviation magnitude function.
// ----------------------------------------------------------------------------
package bnre_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MEAN_W    = 20;
    localparam int THRESH_W  = 16;
    localparam int BLANK_W   = 10;
    localparam int DEV_W     = 21;
    localparam int MAG_W     = 20;
    localparam int SQ_W      = 40;
    localparam int SUM_W     = 64;
    localparam int RMS_W     = 24;
    localparam int CNT_W     = 25;
    localparam int IDX_W     = 25;
    localparam int RESUME_W  = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_MEAN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_AFTER      = 2'd2;

    typedef struct packed {
        logic feed;
        logic clear;
    } t_acc_ctl;

    function automatic logic [MAG_W-1:0] dev_mag(
        input logic [SAMPLE_W-1:0] raw,
        input logic [MEAN_W-1:0]   mean
    );
        logic [DEV_W-1:0] d;
        logic [DEV_W-1:0] m;
        d = {raw[SAMPLE_W-1], raw, 4'b0000} - {mean[MEAN_W-1], mean};
        m = d[DEV_W-1] ? (DEV_W'(0) - d) : d;
        return m[MAG_W-1:0];
    endfunction

endpackage

### design/bnre_line_mem.sv
// ----------------------------------------------------------------------------
// Look-ahead delay line memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bnre_line_mem #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [bnre_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [bnre_pkg::SAMPLE_W-1:0] o_rdata
);

    logic [bnre_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [bnre_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/bnre_sq_acc.sv
// ----------------------------------------------------------------------------
// Squared deviation accumulator
// Three-stage pipe: deviation magnitude, square, saturating 64-bit sum with
// a count of kept samples.
// ----------------------------------------------------------------------------
module bnre_sq_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bnre_pkg::t_acc_ctl            i_ctl,
    input  logic [bnre_pkg::SAMPLE_W-1:0] i_raw,
    input  logic [bnre_pkg::MEAN_W-1:0]   i_mean,
    output logic                          o_busy,
    output logic [bnre_pkg::SUM_W-1:0]    o_sum,
    output logic [bnre_pkg::CNT_W-1:0]    o_count
);

    logic                         r_v1;
    logic                         r_v2;
    logic [bnre_pkg::MAG_W-1:0]   r_mag;
    logic [bnre_pkg::SQ_W-1:0]    r_sq;
    logic [bnre_pkg::SUM_W-1:0]   r_sum;
    logic [bnre_pkg::CNT_W-1:0]   r_count;
    logic [bnre_pkg::SUM_W:0]     tot;
    logic [bnre_pkg::SUM_W-1:0]   n_sum;

    always_comb begin
        tot   = {1'b0, r_sum} + (bnre_pkg::SUM_W + 1)'(r_sq);
        n_sum = tot[bnre_pkg::SUM_W] ? '1 : tot[bnre_pkg::SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_v1 <= i_ctl.feed;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_sum   <= n_sum;
                r_count <= r_count + 1'b1;
            end
        end
        r_mag <= bnre_pkg::dev_mag(i_raw, i_mean);
        r_sq  <= r_mag * r_mag;
    end

    assign o_busy  = r_v1 | r_v2;
    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

### design/bnre_div_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative divide and square root
// One shared subtractor: restoring divide of sum*256 by count, one bit a
// cycle, then a digit-by-digit square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module bnre_div_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bnre_pkg::SUM_W-1:0] i_sum,
    input  logic [bnre_pkg::CNT_W-1:0] i_count,
    output logic                       o_done,
    output logic [bnre_pkg::RMS_W-1:0] o_rms
);

    localparam int DVD_W      = bnre_pkg::SUM_W + 8;
    localparam int QUO_W      = 2 * bnre_pkg::RMS_W;
    localparam int OVF_STEPS  = DVD_W - QUO_W;
    localparam int OP_W       = bnre_pkg::RMS_W + 4;
    localparam int STEP_W     = $clog2(DVD_W);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DVD_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(bnre_pkg::RMS_W - 1);
    localparam logic [STEP_W-1:0] OVF_END   = STEP_W'(OVF_STEPS);

    typedef enum logic [1:0] {
        P_IDLE,
        P_DIV,
        P_SQRT
    } t_phase;

    t_phase                     r_phase;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [DVD_W-1:0]           r_dvd;
    logic [bnre_pkg::CNT_W-1:0] r_div;
    logic [OP_W-1:0]            r_rem;
    logic [QUO_W-1:0]           r_quo;
    logic                       r_ovf;
    logic [bnre_pkg::RMS_W-1:0] r_root;
    logic [bnre_pkg::RMS_W-1:0] r_rms;

    logic [OP_W-1:0] op_a;
    logic [OP_W-1:0] op_b;
    logic [OP_W:0]   diff;
    logic            ge;
    logic [OP_W-1:0] n_rem;
    logic            n_ovf;
    logic [bnre_pkg::RMS_W-1:0] n_root;

    always_comb begin
        if (r_phase == P_SQRT) begin
            op_a = {r_rem[OP_W-3:0], r_quo[QUO_W-1 -: 2]};
            op_b = {2'b00, r_root, 2'b01};
        end else begin
            op_a = {r_rem[OP_W-2:0], r_dvd[DVD_W-1]};
            op_b = OP_W'(r_div);
        end
        diff   = {1'b0, op_a} - {1'b0, op_b};
        ge     = !diff[OP_W];
        n_rem  = ge ? diff[OP_W-1:0] : op_a;
        n_ovf  = r_ovf | (ge && (r_step < OVF_END));
        n_root = {r_root[bnre_pkg::RMS_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_DIV;
                        r_step  <= '0;
                        r_dvd   <= {i_sum, 8'h00};
                        r_div   <= i_count;
                        r_rem   <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                P_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= {r_quo[QUO_W-2:0], ge};
                    r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_ovf  <= n_ovf;
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_LAST) begin
                        r_step <= '0;
                        r_rem  <= '0;
                        r_root <= '0;
                        if (n_ovf) begin
                            r_rms   <= '1;
                            r_done  <= 1'b1;
                            r_phase <= P_IDLE;
                        end else begin
                            r_phase <= P_SQRT;
                        end
                    end
                end
                P_SQRT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
                    r_step <= r_step + 1'b1;
                    if (r_step == SQRT_LAST) begin
                        r_rms   <= n_root;
                        r_done  <= 1'b1;
                        r_phase <= P_IDLE;
                    end
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rms  = r_rms;

endmodule

### design/blanked_noise_rms_estimator.sv
// ----------------------------------------------------------------------------
// Blanked noise RMS estimator
// Estimates the RMS deviation of a sample stream from a configured mean,
// leaving out samples around threshold crossings.
// ----------------------------------------------------------------------------
// Each accepted sample passes through the spike test with the delay line
// read, then the delay line write. When the sample leaving the delay line is
// kept, the three-stage square-and-accumulate pipe must drain before the next
// item is taken. A sample marked last adds a flush of the delay line: a setup
// step, then a read and a use step per held sample (up to LOOKAHEAD). A pipe
// drain follows, then restoring division and square root, all on one shared
// subtractor. Samples beyond MAX_SAMPLES are dropped. The result sits in an
// output register, so the next record may start while it waits.
module blanked_noise_rms_estimator #(
    parameter int LOOKAHEAD   = 32,
    parameter int MAX_SAMPLES = 16777216
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bnre_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                           i_last_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bnre_pkg::RMS_W-1:0]     o_noise_rms,
    output logic [bnre_pkg::CNT_W-1:0]     o_noise_samples,
    output logic                           o_no_noise,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bnre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bnre_pkg::MEAN_W-1:0]    i_cfg_data
);

    localparam int AW = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
    localparam int CW = $clog2(LOOKAHEAD + 1);
    localparam logic [bnre_pkg::IDX_W-1:0] LA_IDX  = bnre_pkg::IDX_W'(LOOKAHEAD);
    localparam logic [bnre_pkg::IDX_W-1:0] MAX_IDX = bnre_pkg::IDX_W'(MAX_SAMPLES);
    localparam logic [AW-1:0] LAST_PTR = AW'(LOOKAHEAD - 1);
    localparam logic [CW-1:0] LA_CNT   = CW'(LOOKAHEAD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_STORE,
        S_FL_INIT,
        S_FL_RD,
        S_FL_USE,
        S_DRAIN,
        S_CALC
    } t_state;

    t_state                            r_state;
    logic                              r_done_wait;
    logic [bnre_pkg::MEAN_W-1:0]       r_mean;
    logic [bnre_pkg::THRESH_W-1:0]     r_thresh;
    logic [bnre_pkg::BLANK_W-1:0]      r_blank;
    logic [bnre_pkg::SAMPLE_W-1:0]     r_sample;
    logic                              r_last;
    logic [bnre_pkg::IDX_W-1:0]        r_index;
    logic [bnre_pkg::RESUME_W-1:0]     r_resume;
    logic [AW-1:0]                     r_wptr;
    logic [AW-1:0]                     r_addr;
    logic [bnre_pkg::IDX_W-1:0]        r_k;
    logic [CW-1:0]                     r_left;
    logic                              r_out_valid;
    logic [bnre_pkg::RMS_W-1:0]        r_out_rms;
    logic [bnre_pkg::CNT_W-1:0]        r_out_samples;
    logic                              r_out_none;

    logic                              in_take;
    logic                              spike;
    logic [bnre_pkg::MAG_W-1:0]        mag;
    logic [bnre_pkg::IDX_W-1:0]        k_store;
    logic                              keep_store;
    logic                              load_out;
    logic [AW-1:0]                     mem_raddr;
    logic [bnre_pkg::SAMPLE_W-1:0]     mem_rdata;
    bnre_pkg::t_acc_ctl                acc_ctl;
    logic                              acc_busy;
    logic [bnre_pkg::SUM_W-1:0]        acc_sum;
    logic [bnre_pkg::CNT_W-1:0]        acc_count;
    logic                              ds_start;
    logic                              ds_done;
    logic [bnre_pkg::RMS_W-1:0]        ds_rms;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        o_ready     = (r_state == S_IDLE) && !r_done_wait && !acc_busy;
        in_take     = i_valid && o_ready;
        mag         = bnre_pkg::dev_mag(r_sample, r_mean);
        spike       = mag[bnre_pkg::MAG_W-1:4] >= r_thresh;
        k_store     = r_index - LA_IDX;
        keep_store  = (r_index >= LA_IDX) && ({1'b0, k_store} >= r_resume);
        load_out    = r_done_wait && (!r_out_valid || i_ready);
        mem_raddr   = (r_state == S_TEST) ? r_wptr : r_addr;
        ds_start    = (r_state == S_DRAIN) && !acc_busy && (acc_count != '0);
        acc_ctl.clear = load_out;
        acc_ctl.feed  = ((r_state == S_STORE) && keep_store) ||
                        ((r_state == S_FL_USE) && ({1'b0, r_k} >= r_resume));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done_wait <= 1'b0;
            r_mean      <= '0;
            r_thresh    <= bnre_pkg::THRESH_W'(100);
            r_blank     <= bnre_pkg::BLANK_W'(64);
            r_index     <= '0;
            r_resume    <= '0;
            r_wptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bnre_pkg::CFG_SIGNAL_MEAN:      r_mean   <= i_cfg_data;
                    bnre_pkg::CFG_DETECT_THRESHOLD: r_thresh <= i_cfg_data[bnre_pkg::THRESH_W-1:0];
                    bnre_pkg::CFG_BLANK_AFTER:      r_blank  <= i_cfg_data[bnre_pkg::BLANK_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid   <= 1'b1;
                r_out_rms     <= (acc_count == '0) ? '0 : ds_rms;
                r_out_samples <= acc_count;
                r_out_none    <= (acc_count == '0);
                r_done_wait   <= 1'b0;
                r_index       <= '0;
                r_resume      <= '0;
                r_wptr        <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_sample <= i_sample;
                        r_last   <= i_last_sample;
                        if (r_index < MAX_IDX) begin
                            r_state <= S_TEST;
                        end else if (i_last_sample) begin
                            r_state <= S_FL_INIT;
                        end
                    end
                end
                S_TEST: begin
                    if (spike) begin
                        r_resume <= {1'b0, r_index} + bnre_pkg::RESUME_W'(1)
                                    + bnre_pkg::RESUME_W'(r_blank);
                    end
                    r_state <= S_STORE;
                end
                S_STORE: begin
                    r_index <= r_index + 1'b1;
                    r_wptr  <= ptr_inc(r_wptr);
                    r_state <= r_last ? S_FL_INIT : S_IDLE;
                end
                S_FL_INIT: begin
                    if (r_index > LA_IDX) begin
                        r_k     <= r_index - LA_IDX;
                        r_addr  <= r_wptr;
                        r_left  <= LA_CNT;
                        r_state <= S_FL_RD;
                    end else begin
                        r_k     <= '0;
                        r_addr  <= '0;
                        r_left  <= r_index[CW-1:0];
                        r_state <= (r_index == '0) ? S_DRAIN : S_FL_RD;
                    end
                end
                S_FL_RD: begin
                    r_state <= S_FL_USE;
                end
                S_FL_USE: begin
                    r_k     <= r_k + 1'b1;
                    r_addr  <= ptr_inc(r_addr);
                    r_left  <= r_left - 1'b1;
                    r_state <= (r_left == CW'(1)) ? S_DRAIN : S_FL_RD;
                end
                S_DRAIN: begin
                    if (!acc_busy && !r_done_wait) begin
                        if (acc_count == '0) begin
                            r_done_wait <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (ds_done) begin
                        r_done_wait <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bnre_line_mem #(
        .DEPTH (LOOKAHEAD)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_state == S_STORE),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bnre_sq_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_raw   (mem_rdata),
        .i_mean  (r_mean),
        .o_busy  (acc_busy),
        .o_sum   (acc_sum),
        .o_count (acc_count)
    );

    bnre_div_sqrt u_div_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ds_start),
        .i_sum   (acc_sum),
        .i_count (acc_count),
        .o_done  (ds_done),
        .o_rms   (ds_rms)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_noise_rms     = r_out_rms;
    assign o_noise_samples = r_out_samples;
    assign o_no_noise      = r_out_none;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Blanked noise RMS estimator testbench
// Streams records of samples through the estimator and checks every result
// against a cycle-free estimate of the blanked RMS. Runs directed corner
// records first, then random records over many register settings, with
// random gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

    import bnre_pkg::*;

    localparam int LOOKAHEAD     = 32;
    localparam int MAX_SAMPLES   = 16777216;
    localparam int SETTLE_CYCLES = 256;
    localparam int QUIET_LIMIT   = 20000;
    localparam int ITEM_TARGET   = 1550;
    localparam int RECORD_TARGET = 30;
    localparam int MEAN_MIN      = -524288;
    localparam int MEAN_MAX      = 524272;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {FEED_SAMPLE, FEED_CFG, FEED_DRAIN} feed_kind_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_pace_e;

    typedef struct packed {
        feed_kind_e            kind;
        logic [SAMPLE_W-1:0]   sample;
        logic                  last;
        logic [CFG_IDX_W-1:0]  idx;
        logic [MEAN_W-1:0]     data;
    } feed_item_t;

    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic [CNT_W-1:0] count;
        logic             empty;
    } rms_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [SAMPLE_W-1:0]  i_sample = '0;
    logic                 i_last_sample = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [RMS_W-1:0]     o_noise_rms;
    logic [CNT_W-1:0]     o_noise_samples;
    logic                 o_no_noise;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [MEAN_W-1:0]    i_cfg_data = '0;

    blanked_noise_rms_estimator #(
        .LOOKAHEAD   (LOOKAHEAD),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_last_sample   (i_last_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_noise_rms     (o_noise_rms),
        .o_noise_samples (o_noise_samples),
        .o_no_noise      (o_no_noise),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    feed_item_t  feed_q[$];
    rms_result_t pending_rms_q[$];
    int          n_items;
    int          n_records;
    int          err_cnt;

    // estimator state
    logic [MEAN_W-1:0]   cur_mean;
    logic [THRESH_W-1:0] cur_thr;
    logic [BLANK_W-1:0]  cur_blank;
    logic [SAMPLE_W-1:0] held_line [LOOKAHEAD];
    longint unsigned     sample_idx;
    longint unsigned     resume_at;
    longint unsigned     sq_sum;
    longint unsigned     kept_cnt;

    function automatic longint unsigned dev_abs(input logic [SAMPLE_W-1:0] raw,
                                                input logic [MEAN_W-1:0] mean);
        longint d;
        d = longint'($signed(raw)) * 16 - longint'($signed(mean));
        return (d < 0) ? longint'(-d) : d;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic clear_record();
        foreach (held_line[i]) held_line[i] = '0;
        sample_idx = 0;
        resume_at  = 0;
        sq_sum     = 0;
        kept_cnt   = 0;
    endtask

    task automatic reset_model();
        cur_mean  = '0;
        cur_thr   = THRESH_W'(100);
        cur_blank = BLANK_W'(64);
        clear_record();
    endtask

    task automatic write_model_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [MEAN_W-1:0] data);
        case (idx)
            CFG_SIGNAL_MEAN:      cur_mean  = data;
            CFG_DETECT_THRESHOLD: cur_thr   = data[THRESH_W-1:0];
            CFG_BLANK_AFTER:      cur_blank = data[BLANK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic fold_held(input longint unsigned k);
        longint unsigned a;
        longint unsigned sq;
        if (k >= resume_at) begin
            a  = dev_abs(held_line[int'(k % LOOKAHEAD)], cur_mean);
            sq = a * a;
            sq_sum = (sq_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                              : sq_sum + sq;
            kept_cnt++;
        end
    endtask

    task automatic take_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
        longint unsigned k;
        longint unsigned q1;
        longint unsigned rem;
        longint unsigned q;
        longint unsigned root;
        rms_result_t     res;
        if (sample_idx < MAX_SAMPLES) begin
            if ((dev_abs(raw, cur_mean) >> 4) >= cur_thr)
                resume_at = sample_idx + 1 + cur_blank;
            if (sample_idx >= LOOKAHEAD) fold_held(sample_idx - LOOKAHEAD);
            held_line[int'(sample_idx % LOOKAHEAD)] = raw;
            sample_idx++;
        end
        if (last) begin
            k = (sample_idx > LOOKAHEAD) ? sample_idx - LOOKAHEAD : 0;
            while (k < sample_idx) begin
                fold_held(k);
                k++;
            end
            root = 0;
            if (kept_cnt != 0) begin
                q1  = sq_sum / kept_cnt;
                rem = sq_sum % kept_cnt;
                q   = (q1 >= 64'h1_0000_0000_0000) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                    : q1 * 256 + (rem * 256) / kept_cnt;
                root = floor_sqrt(q);
                if (root > 64'hFF_FFFF) root = 64'hFF_FFFF;
            end
            res.rms   = RMS_W'(root);
            res.count = CNT_W'(kept_cnt);
            res.empty = (kept_cnt == 0);
            pending_rms_q.push_back(res);
            clear_record();
        end
    endtask

    task automatic queue_sample(input int s, input bit last);
        feed_q.push_back('{FEED_SAMPLE, SAMPLE_W'(s), last, '0, '0});
        n_items++;
        if (last) n_records++;
    endtask

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [MEAN_W-1:0] data);
        feed_q.push_back('{FEED_CFG, '0, 1'b0, idx, data});
    endtask

    task automatic queue_drain();
        feed_q.push_back('{FEED_DRAIN, '0, 1'b0, '0, '0});
    endtask

    task automatic log_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    function automatic int pick_mean();
        case ($urandom_range(0, 7))
            0: return MEAN_MIN;
            1: return MEAN_MAX;
            2: return int'($urandom_range(0, 128)) - 64;
            default: return int'($urandom_range(0, MEAN_MAX - MEAN_MIN)) + MEAN_MIN;
        endcase
    endfunction

    // sample side: driver and input-side prediction
    int burst_left;
    int gap_left;
    int settle;

    always @(posedge i_clk) begin : feed_side
        feed_item_t head;
        logic       go_smp;
        logic       go_cfg;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cfg_valid <= 1'b0;
            reset_model();
            burst_left = 1;
            gap_left   = 0;
            settle     = 0;
        end else begin
            if (i_valid && o_ready) take_sample(i_sample, i_last_sample);
            if (i_cfg_valid && o_cfg_ready) write_model_reg(i_cfg_index, i_cfg_data);
            if ((!i_valid || o_ready) && (!i_cfg_valid || o_cfg_ready)) begin
                go_smp = 1'b0;
                go_cfg = 1'b0;
                if (pending_rms_q.size() == 0) settle++;
                else settle = 0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (feed_q.size() != 0) begin
                    head = feed_q[0];
                    if (head.kind == FEED_SAMPLE) begin
                        head = feed_q.pop_front();
                        go_smp = 1'b1;
                        i_sample      <= head.sample;
                        i_last_sample <= head.last;
                        settle = 0;
                        if (burst_left <= 1) begin
                            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                                     : $urandom_range(1, 24);
                            case ($urandom_range(0, 19))
                                0:             gap_left = $urandom_range(20, 80);
                                1, 2, 3, 4, 5: gap_left = 0;
                                default:       gap_left = $urandom_range(1, 6);
                            endcase
                        end else begin
                            burst_left--;
                        end
                    end else if (settle >= SETTLE_CYCLES) begin
                        head = feed_q.pop_front();
                        settle = 0;
                        if (head.kind == FEED_CFG) begin
                            go_cfg = 1'b1;
                            i_cfg_index <= head.idx;
                            i_cfg_data  <= head.data;
                        end
                    end
                end
                i_valid     <= go_smp;
                i_cfg_valid <= go_cfg;
            end
        end
    end

    // result side: receiver stalls and checking
    rx_pace_e rx_mode;
    int       rx_left;
    int       rx_tick;

    always @(posedge i_clk) begin : result_side
        rms_result_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_mode = RX_OPEN;
            rx_left = 0;
            rx_tick = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_rms_q.size() == 0) begin
                    log_mismatch($sformatf("unexpected result: rms %0d count %0d empty %0b",
                                           o_noise_rms, o_noise_samples, o_no_noise));
                end else begin
                    want = pending_rms_q.pop_front();
                    if (o_noise_rms !== want.rms || o_noise_samples !== want.count ||
                        o_no_noise !== want.empty)
                        log_mismatch($sformatf(
                            "result mismatch: rms exp %0d got %0d, count exp %0d got %0d, %s",
                            want.rms, o_noise_rms, want.count, o_noise_samples,
                            $sformatf("empty exp %0b got %0b", want.empty, o_no_noise)));
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_pace_e'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 300);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_ready <= ($urandom_range(0, 15) == 0);
                default:   i_ready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (i_cfg_valid && o_cfg_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : sequencer
        int gen_mean;
        int gen_thr;
        int spread;
        int rec_len;
        int rec_in_phase;
        int mid_at;
        int pos;
        int v;
        bit wild_rec;
        n_items   = 0;
        n_records = 0;
        err_cnt   = 0;

        // reset settings: short record, lone spikes, spike blanking its neighbors
        queue_sample(0, 1'b0);
        queue_sample(99, 1'b0);
        queue_sample(-99, 1'b0);
        queue_sample(1, 1'b1);
        queue_sample(32767, 1'b1);
        queue_sample(-32768, 1'b1);
        queue_sample(12, 1'b0);
        queue_sample(-100, 1'b0);
        queue_sample(7, 1'b1);

        // lowest mean, highest threshold, no blanking after
        queue_cfg(CFG_SIGNAL_MEAN, MEAN_W'(MEAN_MIN));
        queue_cfg(CFG_DETECT_THRESHOLD, MEAN_W'(65535));
        queue_cfg(CFG_BLANK_AFTER, MEAN_W'(0));
        queue_sample(-32768, 1'b0);
        queue_sample(32766, 1'b1);
        queue_sample(32767, 1'b1);

        // highest mean, zero threshold: every sample blanked
        queue_cfg(CFG_SIGNAL_MEAN, MEAN_W'(MEAN_MAX));
        queue_cfg(CFG_DETECT_THRESHOLD, MEAN_W'(0));
        queue_cfg(CFG_BLANK_AFTER, MEAN_W'(1023));
        queue_cfg(CFG_SPARE, MEAN_W'($urandom));
        queue_sample(-32768, 1'b0);
        queue_sample(5, 1'b1);

        // fractional mean: truncation of the distance in the spike test
        queue_cfg(CFG_SIGNAL_MEAN, MEAN_W'(-7));
        queue_cfg(CFG_DETECT_THRESHOLD, MEAN_W'(1));
        queue_cfg(CFG_BLANK_AFTER, MEAN_W'(0));
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(0, 1'b1);
        queue_drain();

        gen_mean     = -7;
        gen_thr      = 1;
        rec_in_phase = 0;
        while (n_items < ITEM_TARGET || n_records < RECORD_TARGET) begin
            if (rec_in_phase == 0) begin
                rec_in_phase = $urandom_range(2, 6);
                if ($urandom_range(0, 3) != 0) begin
                    gen_mean = pick_mean();
                    queue_cfg(CFG_SIGNAL_MEAN, MEAN_W'(gen_mean));
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       gen_thr = 0;
                        1:       gen_thr = 65535;
                        2:       gen_thr = $urandom_range(0, 65535);
                        default: gen_thr = $urandom_range(4, 400);
                    endcase
                    queue_cfg(CFG_DETECT_THRESHOLD, {4'($urandom), THRESH_W'(gen_thr)});
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       v = 0;
                        1:       v = 1023;
                        2:       v = $urandom_range(0, 1023);
                        default: v = $urandom_range(1, 48);
                    endcase
                    queue_cfg(CFG_BLANK_AFTER, {10'($urandom), BLANK_W'(v)});
                end
                if ($urandom_range(0, 7) == 0) queue_cfg(CFG_SPARE, MEAN_W'($urandom));
            end
            spread = gen_thr * 7 / 8 + 2;
            if (spread > 32767) spread = 32767;
            case ($urandom_range(0, 23))
                0, 1, 2, 3: rec_len = $urandom_range(1, 8);
                4, 5, 6:    rec_len = $urandom_range(100, 300);
                default:    rec_len = $urandom_range(9, 70);
            endcase
            mid_at   = ($urandom_range(0, 9) == 0 && rec_len > 1) ?
                       $urandom_range(1, rec_len - 1) : -1;
            wild_rec = ($urandom_range(0, 11) == 0);
            for (pos = 0; pos < rec_len; pos++) begin
                // move the mean while samples still sit in the delay line
                if (pos == mid_at) begin
                    gen_mean = pick_mean();
                    queue_cfg(CFG_SIGNAL_MEAN, MEAN_W'(gen_mean));
                end
                if (wild_rec || $urandom_range(0, 19) == 0) begin
                    v = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    v = (gen_mean >>> 4) + int'($urandom_range(0, 2 * spread)) - spread;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                end
                queue_sample(v, pos == rec_len - 1);
            end
            rec_in_phase--;
            if ($urandom_range(0, 14) == 0) queue_drain();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_valid || i_cfg_valid) @(negedge i_clk);
        while (pending_rms_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (err_cnt == 0 && pending_rms_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
